### sv/assert_macros.svh
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### sv/kcse_pkg.sv
// ----------------------------------------------------------------------------
// kcse_pkg
// shared codes and constants of the keyframe curve evaluator
// ----------------------------------------------------------------------------
package kcse_pkg;
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_EVAL   = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam int KEY_W = 64;
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;
endpackage

### sv/keyframe_curve_smoothstep_eval_core.sv
// ----------------------------------------------------------------------------
// keyframe_curve_smoothstep_eval_core
// time-sorted keyframe table in ram, insert/remove by shifting, smoothstep eval
// ----------------------------------------------------------------------------
// insert walks down from the top, shifting up each key later than the new time, then
// writes the new key; remove shifts each later key down; evaluate returns the first
// or last key's value outside their times, else scans for the segment, then divides,
// smoothsteps and blends; one word at a time, held off by the ram walk and divider
// reset: key count cleared, ram content left undefined
`include "assert_macros.svh"

module keyframe_curve_smoothstep_eval_core #(
    parameter int KEY_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], time_point[17:2], value_x[33:18], value_y[49:34],
    // value_z[65:50], entry_index[69:66], zero fill
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_x[15:0], out_y[31:16], out_z[47:32], status[49:48],
    // key_count[54:50], zero fill
    output logic [55:0] m_tdata
);
    localparam int AW = $clog2(KEY_DEPTH);
    localparam int CW = $clog2(KEY_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INSRD = 4'd1;
    localparam logic [3:0] S_INSCK = 4'd2;
    localparam logic [3:0] S_REMRD = 4'd3;
    localparam logic [3:0] S_REMWR = 4'd4;
    localparam logic [3:0] S_EVRD  = 4'd5;
    localparam logic [3:0] S_EVCK  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_SM    = 4'd9;
    localparam logic [3:0] S_BL    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_INSWR = 4'd12;
    localparam logic [3:0] S_LSTRD = 4'd13;
    localparam logic [3:0] S_LSTCK = 4'd14;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] total_reg, total_next;
    logic [15:0] tp_reg, tp_next;
    logic [47:0] val_reg, val_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [63:0] prev_reg, prev_next;
    logic [63:0] cur_reg, cur_next;
    logic [15:0] d_reg, d_next, w_reg, w_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] q_reg, q_next;
    logic [4:0]  bit_reg, bit_next;
    logic [15:0] t_reg, t_next, s_reg, s_next;
    logic [31:0] t2_reg, t2_next;
    logic [47:0] res_reg, res_next;
    logic [1:0]  stat_reg, stat_next;
    logic        mv_reg, mv_next;
    logic [1:0]  cc_reg, cc_next;
    logic [55:0] out_reg, out_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    kcse_ram #(.WIDTH(kcse_pkg::KEY_W), .DEPTH(KEY_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // output word is held apart from the working registers
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    // remainder step of the restoring divider
    logic [17:0] rsh;
    logic [17:0] rdiff;
    // blend helpers
    logic signed [16:0] ca, cb, diff;
    logic signed [33:0] prod;
    logic signed [17:0] qv;
    logic [33:0] sm;
    logic [33:0] t2s;

    always_comb begin
        state_next = state_reg; total_next = total_reg;
        tp_next = tp_reg; val_next = val_reg;
        ptr_next = ptr_reg; prev_next = prev_reg; cur_next = cur_reg;
        d_next = d_reg; w_next = w_reg; rem_next = rem_reg; q_next = q_reg;
        bit_next = bit_reg; t_next = t_reg; s_next = s_reg; t2_next = t2_reg;
        res_next = res_reg; stat_next = stat_reg; mv_next = mv_reg; cc_next = cc_reg;
        out_next = out_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        rsh = {rem_reg, 1'b0};
        rdiff = rsh - {2'b0, w_reg};
        ca = '0; cb = '0; diff = '0; prod = '0; qv = '0; sm = '0; t2s = '0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    tp_next = s_tdata[17:2];
                    val_next = {s_tdata[33:18], s_tdata[49:34], s_tdata[65:50]};
                    res_next = '0;
                    stat_next = kcse_pkg::ST_OK;
                    case (s_tdata[1:0])
                        kcse_pkg::FUNC_INSERT: begin
                            if (total_reg >= CW'(KEY_DEPTH)) begin
                                stat_next = kcse_pkg::ST_FULL;
                                state_next = S_OUT;
                            end else begin
                                // shift from the top down while key time > new time
                                ptr_next = total_reg;
                                state_next = S_INSRD;
                            end
                        end
                        kcse_pkg::FUNC_REMOVE: begin
                            if ({{(CW > 4 ? CW - 4 : 0){1'b0}}, s_tdata[69:66]} >=
                                total_reg) begin
                                stat_next = kcse_pkg::ST_BADIDX;
                                state_next = S_OUT;
                            end else begin
                                ptr_next = CW'(s_tdata[69:66]);
                                state_next = S_REMRD;
                            end
                        end
                        kcse_pkg::FUNC_EVAL: begin
                            if (total_reg == '0) begin
                                stat_next = kcse_pkg::ST_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                ptr_next = '0;
                                state_next = S_EVRD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_INSRD: begin
                if (ptr_reg == '0) begin
                    state_next = S_INSWR;
                end else begin
                    raddr = AW'(ptr_reg - 1'b1);
                    state_next = S_INSCK;
                end
            end
            S_INSCK: begin
                if (rdata[63:48] > tp_reg) begin
                    we = 1'b1; waddr = AW'(ptr_reg); wdata = rdata;
                    ptr_next = ptr_reg - 1'b1;
                    state_next = S_INSRD;
                end else begin
                    state_next = S_INSWR;
                end
            end
            S_INSWR: begin
                we = 1'b1; waddr = AW'(ptr_reg); wdata = {tp_reg, val_reg};
                total_next = total_reg + 1'b1;
                state_next = S_OUT;
            end
            S_REMRD: begin
                if (ptr_reg + 1'b1 >= total_reg) begin
                    total_next = total_reg - 1'b1;
                    state_next = S_OUT;
                end else begin
                    raddr = AW'(ptr_reg + 1'b1);
                    state_next = S_REMWR;
                end
            end
            S_REMWR: begin
                we = 1'b1; waddr = AW'(ptr_reg); wdata = rdata;
                ptr_next = ptr_reg + 1'b1;
                state_next = S_REMRD;
            end
            S_EVRD: begin
                raddr = AW'(ptr_reg);
                state_next = S_EVCK;
            end
            S_EVCK: begin
                cur_next = rdata;
                if (ptr_reg == '0) begin
                    prev_next = rdata;
                    if (tp_reg <= rdata[63:48]) begin
                        res_next = rdata[47:0];
                        state_next = S_OUT;
                    end else begin
                        state_next = S_LSTRD;
                    end
                end else if (tp_reg <= rdata[63:48]) begin
                    // first segment holding the time
                    d_next = tp_reg - prev_reg[63:48];
                    w_next = rdata[63:48] - prev_reg[63:48];
                    rem_next = '0;
                    q_next = '0;
                    bit_next = 5'd31;
                    state_next = S_DIV;
                end else if (ptr_reg + 1'b1 >= total_reg) begin
                    res_next = rdata[47:0];
                    state_next = S_OUT;
                end else begin
                    prev_next = rdata;
                    ptr_next = ptr_reg + 1'b1;
                    state_next = S_EVRD;
                end
            end
            S_LSTRD: begin
                raddr = AW'(total_reg - 1'b1);
                state_next = S_LSTCK;
            end
            S_LSTCK: begin
                // at or past the last key time the last value is returned as is
                if (tp_reg >= rdata[63:48]) begin
                    res_next = rdata[47:0];
                    state_next = S_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                    state_next = S_EVRD;
                end
            end
            S_DIV: begin
                // restoring divide of d<<16 by w, 32 dividend bits, 1 per cycle
                if (w_reg == '0) begin
                    t_next = '0;
                    state_next = S_SQ;
                end else begin
                    if (bit_reg >= 5'd16) begin
                        rsh = {rem_reg, d_reg[bit_reg[3:0]]};
                    end else begin
                        rsh = {rem_reg, 1'b0};
                    end
                    rdiff = rsh - {2'b0, w_reg};
                    if (!rdiff[17]) begin
                        rem_next = rdiff[16:0];
                        q_next = {q_reg[15:0], 1'b1} | {q_reg[16], 16'b0};
                    end else begin
                        rem_next = rsh[16:0];
                        q_next = {q_reg[15:0], 1'b0} | {q_reg[16], 16'b0};
                    end
                    bit_next = bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ: begin
                if (w_reg != '0) begin
                    t_next = q_reg[16] ? 16'hFFFF : q_reg[15:0];
                end
                cc_next = '0;
                state_next = S_SM;
            end
            S_SM: begin
                if (cc_reg == '0) begin
                    t2_next = t_reg * t_reg;
                    cc_next = 2'd1;
                end else begin
                    t2s = {2'b0, t2_reg[31:16]} *
                          (kcse_pkg::SMOOTH_THREE - {1'b0, t_reg, 1'b0});
                    s_next = (t2s[33:16] > 18'd65535) ? 16'hFFFF : t2s[31:16];
                    cc_next = '0;
                    state_next = S_BL;
                end
            end
            S_BL: begin
                // one component per cycle, z first then y then x
                ca = 17'(signed'(prev_reg[16*cc_reg +: 16]));
                cb = 17'(signed'(cur_reg[16*cc_reg +: 16]));
                diff = cb - ca;
                prod = diff * $signed({1'b0, s_reg});
                qv = 18'(prod >>> 16);
                res_next[16*cc_reg +: 16] = 16'(ca + 17'(qv));
                cc_next = cc_reg + 1'b1;
                if (cc_reg == 2'd2) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    out_next = {1'b0, 5'(total_reg), stat_reg,
                                res_reg[15:0], res_reg[31:16], res_reg[47:32]};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            mv_reg <= 1'b0;
            cc_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            mv_reg <= mv_next;
            cc_reg <= cc_next;
        end
        tp_reg <= tp_next; val_reg <= val_next;
        ptr_reg <= ptr_next; prev_reg <= prev_next;
        cur_reg <= cur_next; d_reg <= d_next; w_reg <= w_next;
        rem_reg <= rem_next; q_reg <= q_next; bit_reg <= bit_next;
        t_reg <= t_next; s_reg <= s_next; t2_reg <= t2_next;
        res_reg <= res_next; stat_reg <= stat_next; out_reg <= out_next;
    end

    `ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, total_reg <= CW'(KEY_DEPTH))
    `ASSERT_IMP(a_busy_no_accept, aclk, aresetn, state_reg != S_IDLE, !s_tready)
    `ASSERT_NEXT(a_full_keeps, aclk, aresetn,
        s_tvalid && s_tready && s_tdata[1:0] == kcse_pkg::FUNC_INSERT &&
        total_reg == CW'(KEY_DEPTH), total_reg == CW'(KEY_DEPTH))
    `ASSERT_IMP(a_empty_status, aclk, aresetn,
        m_tvalid && m_tdata[49:48] == kcse_pkg::ST_EMPTY, m_tdata[47:0] == '0)
endmodule

### sv/kcse_ram.sv
// ----------------------------------------------------------------------------
// kcse_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module kcse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sim/keyframe_curve_smoothstep_eval_core_tb.sv
// ----------------------------------------------------------------------------
// keyframe_curve_smoothstep_eval_core_tb
// keyframe table insert/remove/evaluate checked word by word against a predictor
// ----------------------------------------------------------------------------
module keyframe_curve_smoothstep_eval_core_tb;
    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] kt;
        logic [15:0] kx;
        logic [15:0] ky;
        logic [15:0] kz;
    } key_t;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] tp;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [3:0]  idx;
    } op_t;

    typedef struct {
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] oz;
        logic [1:0]  st;
        logic [4:0]  cnt;
    } res_t;

    typedef struct {
        op_t  op;
        bit   has_exp;
        res_t exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    key_t  keys[DEPTH];
    int    nkeys = 0;
    res_t  pending_results[$];
    int    failures = 0;
    int    idle_cycles = 0;
    bit    hold_rx = 0;
    bit    quiet = 0;
    row_t  directed[$];

    always #5 aclk = ~aclk;

    keyframe_curve_smoothstep_eval_core #(.KEY_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic [31:0] smooth_frac(logic [31:0] d, logic [31:0] w);
        logic [63:0] t, t2, s;
        if (w == 0) return 0;
        t = ({32'd0, d} << 16) / w;
        if (t > 65535) t = 65535;
        t2 = (t * t) >> 16;
        s = (t2 * (64'd196608 - 2 * t)) >> 16;
        if (s > 65535) s = 65535;
        return s[31:0];
    endfunction

    function automatic logic [15:0] mix(logic signed [15:0] a, logic signed [15:0] b,
                                        logic [31:0] s);
        longint prod, q;
        prod = (longint'(b) - longint'(a)) * longint'(s);
        if (prod >= 0) q = prod >>> 16;
        else q = -((-prod + 65535) >>> 16);
        return 16'(longint'(a) + q);
    endfunction

    // updates the key table and returns the word the block should produce
    function automatic res_t curve_apply(op_t op);
        res_t r;
        int pos, i;
        logic [31:0] s;
        bit found;
        key_t ka, kb;
        r = '{default: '0};
        case (op.func)
            kcse_pkg::FUNC_INSERT: begin
                if (nkeys >= DEPTH) begin
                    r.st = kcse_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < nkeys && keys[pos].kt <= op.tp) pos++;
                    for (i = nkeys; i > pos; i--) keys[i] = keys[i-1];
                    keys[pos] = '{op.tp, op.vx, op.vy, op.vz};
                    nkeys++;
                end
            end
            kcse_pkg::FUNC_REMOVE: begin
                if (op.idx >= nkeys) begin
                    r.st = kcse_pkg::ST_BADIDX;
                end else begin
                    for (i = op.idx; i + 1 < nkeys; i++) keys[i] = keys[i+1];
                    nkeys--;
                end
            end
            kcse_pkg::FUNC_EVAL: begin
                if (nkeys == 0) begin
                    r.st = kcse_pkg::ST_EMPTY;
                end else if (op.tp <= keys[0].kt) begin
                    {r.ox, r.oy, r.oz} = {keys[0].kx, keys[0].ky, keys[0].kz};
                end else begin
                    ka = keys[nkeys-1];
                    {r.ox, r.oy, r.oz} = {ka.kx, ka.ky, ka.kz};
                    found = 0;
                    if (op.tp < ka.kt) begin
                        for (i = 0; i + 1 < nkeys && !found; i++) begin
                            ka = keys[i];
                            kb = keys[i+1];
                            if (op.tp >= ka.kt && op.tp <= kb.kt) begin
                                s = smooth_frac(op.tp - ka.kt, kb.kt - ka.kt);
                                r.ox = mix(ka.kx, kb.kx, s);
                                r.oy = mix(ka.ky, kb.ky, s);
                                r.oz = mix(ka.kz, kb.kz, s);
                                found = 1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.cnt = 5'(nkeys);
        return r;
    endfunction

    task automatic send_word(op_t op);
        s_tdata  <= {2'b00, op.idx, op.vz, op.vy, op.vx, op.tp, op.func};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic offer(op_t op, bit has_exp, res_t exp);
        res_t r;
        // occasional gap before the word, none during the quiet stretch
        if (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        r = curve_apply(op);
        if (has_exp && {r.ox, r.oy, r.oz, r.st, r.cnt} !=
                       {exp.ox, exp.oy, exp.oz, exp.st, exp.cnt}) begin
            $error("directed row disagrees with predictor func=%0d", op.func);
            failures++;
        end
        pending_results = {pending_results, r};
        send_word(op);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic add_row(op_t op, bit has_exp, res_t exp);
        row_t row;
        row.op = op;
        row.has_exp = has_exp;
        row.exp = exp;
        directed = {directed, row};
    endtask

    function automatic op_t make_op(logic [1:0] f, logic [15:0] tp, logic [15:0] vx,
                                    logic [15:0] vy, logic [15:0] vz, logic [3:0] idx);
        op_t o;
        o = '{f, tp, vx, vy, vz, idx};
        return o;
    endfunction

    function automatic res_t make_res(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                      logic [1:0] st, logic [4:0] cnt);
        res_t r;
        r = '{x, y, z, st, cnt};
        return r;
    endfunction

    function automatic op_t rand_op(int clustered);
        op_t o;
        int p;
        p = $urandom_range(99);
        o.func = p < 40 ? kcse_pkg::FUNC_INSERT :
                 p < 58 ? kcse_pkg::FUNC_REMOVE :
                 p < 96 ? kcse_pkg::FUNC_EVAL : kcse_pkg::FUNC_NOP;
        // narrow time window makes equal and nearby times common
        o.tp  = clustered ? 16'($urandom_range(16'h1000, 16'h1040)) : 16'($urandom);
        o.vx  = 16'($urandom);
        o.vy  = 16'($urandom);
        o.vz  = 16'($urandom);
        o.idx = 4'($urandom_range(0, nkeys < 16 ? nkeys : 15));
        if ($urandom_range(9) == 0) o.idx = 4'($urandom);
        return o;
    endfunction

    // result side: random stalls plus a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn || hold_rx) m_tready <= 1'b0;
        else m_tready <= quiet || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[49:48],
                    m_tdata[54:50]};
            if (pending_results.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (got.ox !== want.ox) begin
                    $error("out_x exp %h got %h", want.ox, got.ox); failures++;
                end
                if (got.oy !== want.oy) begin
                    $error("out_y exp %h got %h", want.oy, got.oy); failures++;
                end
                if (got.oz !== want.oz) begin
                    $error("out_z exp %h got %h", want.oz, got.oz); failures++;
                end
                if (got.st !== want.st) begin
                    $error("status exp %0d got %0d", want.st, got.st); failures++;
                end
                if (got.cnt !== want.cnt) begin
                    $error("key_count exp %0d got %0d", want.cnt, got.cnt); failures++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("keyframe_curve_smoothstep_eval_core: mismatch");
            $finish;
        end
    end

    initial begin
        res_t none;
        none = '{default: '0};
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h0000, 0, 0, 0, 0), 1,
                make_res(0, 0, 0, kcse_pkg::ST_EMPTY, 0));
        add_row(make_op(kcse_pkg::FUNC_REMOVE, 0, 0, 0, 0, 4'd0), 1,
                make_res(0, 0, 0, kcse_pkg::ST_BADIDX, 0));
        add_row(make_op(kcse_pkg::FUNC_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        4'hf), 1, none);
        add_row(make_op(kcse_pkg::FUNC_INSERT, 16'h0100, 16'h7fff, 16'h8000, 16'h0000,
                        0), 1, make_res(0, 0, 0, kcse_pkg::ST_OK, 1));
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h0000, 0, 0, 0, 0), 1,
                make_res(16'h7fff, 16'h8000, 16'h0000, kcse_pkg::ST_OK, 1));
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'hffff, 0, 0, 0, 0), 1,
                make_res(16'h7fff, 16'h8000, 16'h0000, kcse_pkg::ST_OK, 1));
        add_row(make_op(kcse_pkg::FUNC_INSERT, 16'h0200, 16'h8000, 16'h7fff, 16'h0100,
                        0), 1, make_res(0, 0, 0, kcse_pkg::ST_OK, 2));
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h0180, 0, 0, 0, 0), 0, none);
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h0101, 0, 0, 0, 0), 0, none);
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h01ff, 0, 0, 0, 0), 0, none);
        // zero-width segment, then a time on an inner key
        add_row(make_op(kcse_pkg::FUNC_INSERT, 16'h0200, 16'h1234, 16'h5678, 16'h9abc,
                        0), 1, make_res(0, 0, 0, kcse_pkg::ST_OK, 3));
        add_row(make_op(kcse_pkg::FUNC_INSERT, 16'hffff, 16'h0001, 16'hffff, 16'h4000,
                        0), 1, make_res(0, 0, 0, kcse_pkg::ST_OK, 4));
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h0200, 0, 0, 0, 0), 0, none);
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h8000, 0, 0, 0, 0), 0, none);
        add_row(make_op(kcse_pkg::FUNC_REMOVE, 0, 0, 0, 0, 4'd4), 1,
                make_res(0, 0, 0, kcse_pkg::ST_BADIDX, 4));
        add_row(make_op(kcse_pkg::FUNC_REMOVE, 0, 0, 0, 0, 4'd1), 1,
                make_res(0, 0, 0, kcse_pkg::ST_OK, 3));
        add_row(make_op(kcse_pkg::FUNC_EVAL, 16'h0150, 0, 0, 0, 0), 0, none);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) offer(directed[i].op, directed[i].has_exp, directed[i].exp);

        // fill to full and overflow, then empty by removes
        for (int i = 0; i < 14; i++)
            offer(make_op(kcse_pkg::FUNC_INSERT, 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 0), 0, none);
        for (int i = 0; i < 4; i++)
            offer(make_op(kcse_pkg::FUNC_EVAL, 16'($urandom), 0, 0, 0, 0), 0, none);
        offer(make_op(kcse_pkg::FUNC_INSERT, 16'h0, 0, 0, 0, 0), 1,
              make_res(0, 0, 0, kcse_pkg::ST_FULL, 16));
        offer(make_op(kcse_pkg::FUNC_REMOVE, 0, 0, 0, 0, 4'hf), 0, none);
        while (nkeys > 0)
            offer(make_op(kcse_pkg::FUNC_REMOVE, 0, 0, 0, 0,
                          4'($urandom_range(0, nkeys - 1))), 0, none);

        // sender waits for every result
        drain();

        // receiver holds off while words keep coming
        fork
            begin
                hold_rx = 1;
                repeat (300) @(posedge aclk);
                hold_rx = 0;
            end
            for (int i = 0; i < 20; i++) offer(rand_op(0), 0, none);
        join

        for (int n = 0; n < 1100; n++) begin
            quiet = (n >= 400 && n < 550);
            offer(rand_op(n % 200 < 100), 0, none);
        end
        quiet = 0;
        drain();
        repeat (200) @(posedge aclk);

        if (failures == 0 && pending_results.size() == 0)
            $display("keyframe_curve_smoothstep_eval_core: match");
        else
            $display("keyframe_curve_smoothstep_eval_core: mismatch");
        $finish;
    end
endmodule
